// ----- hdl/assert_macros.svh -----
// assertion macros used by the timer bank sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// clocked check, suspended while reset is asserted
`define MTB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check that also holds during reset
`define MTB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MTB_ASSERT(lbl, prop, msg)
`define MTB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/mtb_pkg.sv -----
// shared types and constants of the timer bank
package mtb_pkg;

    localparam int TIMER_COUNT_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    // entry zero is reserved: allocate never hands it out
    localparam int RESERVED_ID = 0;
    localparam int ALLOC_RESET = RESERVED_ID + 1;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_ALLOC = 3'd1;
    localparam logic [2:0] CMD_START = 3'd2;
    localparam logic [2:0] CMD_STOP  = 3'd3;
    localparam logic [2:0] CMD_QUERY = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_TICK,
        ST_WAIT_OUT
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

// ----- hdl/mtb_store.sv -----
// timer entry memory with per-entry valid bits for the zero reset state
module mtb_store
    import mtb_pkg::*;
#(
    parameter int TIMER_COUNT = TIMER_COUNT_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    localparam int AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1,
    localparam int DW = 2 * COUNT_WIDTH + 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  mem_ctl_t      mem_ctl,
    input  logic [AW-1:0] rd_addr,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0]          mem [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] valid_reg;
    logic [DW-1:0]          rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (mem_ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- hdl/mtb_ctrl.sv -----
// command sequencer: read-modify-write of timer entries and result register
`include "assert_macros.svh"
module mtb_ctrl
    import mtb_pkg::*;
#(
    parameter int TIMER_COUNT = TIMER_COUNT_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    localparam int AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1,
    localparam int NW = $clog2(TIMER_COUNT + 1),
    localparam int DW = 2 * COUNT_WIDTH + 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [2:0]    command,
    input  logic [3:0]    timer_id,
    input  logic [31:0]   period_ticks,
    input  logic          periodic_mode,
    input  logic          notify_enable,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          status,
    output logic [3:0]    allocated_id,
    output logic          expired_flag,
    output logic [15:0]   event_mask,
    output mem_ctl_t      mem_ctl,
    output logic [AW-1:0] rd_addr,
    output logic [AW-1:0] wr_addr,
    output logic [DW-1:0] wr_data,
    input  logic [DW-1:0] rd_data
);

    localparam int CW = COUNT_WIDTH;

    state_t        state_reg, state_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [AW-1:0] id_reg, id_next;
    logic [NW-1:0] alloc_cnt_reg, alloc_cnt_next;
    logic [AW:0]   idx_reg, idx_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [AW-1:0] wb_idx_reg, wb_idx_next;
    logic [15:0]   events_reg, events_next;

    logic          pend_status_reg, pend_status_next;
    logic [3:0]    pend_alloc_reg, pend_alloc_next;
    logic          pend_exp_reg, pend_exp_next;

    logic          out_valid_reg, out_valid_next;
    logic          status_reg, status_next;
    logic [3:0]    alloc_id_reg, alloc_id_next;
    logic          exp_flag_reg, exp_flag_next;
    logic [15:0]   event_mask_reg, event_mask_next;

    logic          accept;
    logic          id_ok;
    logic          out_free;
    logic [CW-1:0] cur_period;
    logic [CW-1:0] cur_count;
    logic          cur_mode;
    logic          cur_running;
    logic          cur_notify;
    logic [CW-1:0] dec_count;
    logic [CW-1:0] new_period;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign id_ok      = (32'(timer_id) < 32'(alloc_cnt_reg));
    assign new_period = CW'(period_ticks);

    // entry layout: period, count, mode, running, expired, notify
    assign cur_period  = rd_data[DW-1 -: CW];
    assign cur_count   = rd_data[CW+3:4];
    assign cur_mode    = rd_data[3];
    assign cur_running = rd_data[2];
    assign cur_notify  = rd_data[0];
    assign dec_count   = cur_count - CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alloc_cnt_reg <= NW'(ALLOC_RESET);
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alloc_cnt_reg <= alloc_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        id_reg          <= id_next;
        idx_reg         <= idx_next;
        wb_idx_reg      <= wb_idx_next;
        events_reg      <= events_next;
        pend_status_reg <= pend_status_next;
        pend_alloc_reg  <= pend_alloc_next;
        pend_exp_reg    <= pend_exp_next;
        status_reg      <= status_next;
        alloc_id_reg    <= alloc_id_next;
        exp_flag_reg    <= exp_flag_next;
        event_mask_reg  <= event_mask_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        id_next          = id_reg;
        alloc_cnt_next   = alloc_cnt_reg;
        idx_next         = idx_reg;
        rd_pend_next     = 1'b0;
        wb_idx_next      = wb_idx_reg;
        events_next      = events_reg;
        pend_status_next = pend_status_reg;
        pend_alloc_next  = pend_alloc_reg;
        pend_exp_next    = pend_exp_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        alloc_id_next    = alloc_id_reg;
        exp_flag_next    = exp_flag_reg;
        event_mask_next  = event_mask_reg;
        mem_ctl          = '0;
        rd_addr          = AW'(timer_id);
        wr_addr          = AW'(timer_id);
        wr_data          = {new_period, new_period, periodic_mode, 1'b1, 1'b0, notify_enable};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next         = command;
                    id_next          = AW'(timer_id);
                    pend_status_next = 1'b0;
                    pend_alloc_next  = '0;
                    pend_exp_next    = 1'b0;
                    events_next      = '0;
                    state_next       = ST_WAIT_OUT;
                    case (command)
                        CMD_TICK:
                        begin
                            idx_next   = '0;
                            state_next = ST_TICK;
                        end
                        CMD_ALLOC:
                        begin
                            if (32'(alloc_cnt_reg) >= TIMER_COUNT)
                            begin
                                pend_status_next = 1'b1;
                            end
                            else
                            begin
                                pend_alloc_next = 4'(alloc_cnt_reg);
                                alloc_cnt_next  = alloc_cnt_reg + NW'(1);
                            end
                        end
                        CMD_START:
                        begin
                            // start needs no read: the whole entry is rewritten
                            if (id_ok)
                            begin
                                mem_ctl.wr_en = 1'b1;
                            end
                            else
                            begin
                                pend_status_next = 1'b1;
                            end
                        end
                        CMD_STOP, CMD_QUERY:
                        begin
                            if (id_ok)
                            begin
                                mem_ctl.rd_en = 1'b1;
                                state_next    = ST_MOD;
                            end
                            else
                            begin
                                pend_status_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            pend_status_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_MOD:
            begin
                wr_addr       = id_reg;
                mem_ctl.wr_en = 1'b1;
                if (cmd_reg == CMD_STOP)
                begin
                    wr_data = {cur_period, cur_period, cur_mode, 1'b0, 1'b1, cur_notify};
                end
                else
                begin
                    pend_exp_next = rd_data[1];
                    wr_data       = {rd_data[DW-1:2], 1'b0, rd_data[0]};
                end
                state_next = ST_WAIT_OUT;
            end

            ST_TICK:
            begin
                // one read issued per cycle, each write-back in the cycle after its read
                rd_addr = idx_reg[AW-1:0];
                if (32'(idx_reg) < TIMER_COUNT)
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_pend_next  = 1'b1;
                    wb_idx_next   = idx_reg[AW-1:0];
                    idx_next      = idx_reg + (AW+1)'(1);
                end
                wr_addr = wb_idx_reg;
                if (rd_pend_reg)
                begin
                    if (cur_running)
                    begin
                        mem_ctl.wr_en = 1'b1;
                        if (dec_count == '0)
                        begin
                            if (cur_notify && (32'(wb_idx_reg) < 16))
                            begin
                                events_next = events_reg | (16'(1) << wb_idx_reg);
                            end
                            wr_data = {cur_period, cur_mode ? cur_period : dec_count,
                                       cur_mode, cur_mode, 1'b1, cur_notify};
                        end
                        else
                        begin
                            wr_data = {cur_period, dec_count, cur_mode, 1'b1,
                                       rd_data[1], cur_notify};
                        end
                    end
                    if (32'(wb_idx_reg) == TIMER_COUNT - 1)
                    begin
                        state_next = ST_WAIT_OUT;
                    end
                end
            end

            ST_WAIT_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = pend_status_reg;
                    alloc_id_next   = pend_alloc_reg;
                    exp_flag_next   = pend_exp_reg;
                    event_mask_next = (cmd_reg == CMD_TICK) ? events_reg : '0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign allocated_id = alloc_id_reg;
    assign expired_flag = exp_flag_reg;
    assign event_mask   = event_mask_reg;

    `MTB_ASSERT(a_alloc_range, (32'(alloc_cnt_reg) >= 1) && (32'(alloc_cnt_reg) <= TIMER_COUNT), "allocation count out of range")
    `MTB_ASSERT(a_no_rw_clash, (mem_ctl.rd_en && mem_ctl.wr_en) |-> (rd_addr != wr_addr), "read and write of the same entry in one cycle")
    `MTB_ASSERT(a_alloc_step, (accept && (command == CMD_ALLOC) && (32'(alloc_cnt_reg) < TIMER_COUNT)) |=> (alloc_cnt_reg == $past(alloc_cnt_reg) + NW'(1)), "allocate did not advance the count")
    `MTB_ASSERT(a_result_load, ((state_reg == ST_WAIT_OUT) && out_free) |=> (out_valid && (state_reg == ST_IDLE)), "finished result not loaded")
    `MTB_ASSERT(a_result_hold, (out_valid && out_stall) |=> (out_valid && $stable({status, allocated_id, expired_flag, event_mask})), "stalled result beat changed")

endmodule

// ----- hdl/multi_timer_bank_unit.sv -----
// top level of the multi timer bank: sequencer plus entry memory
// A bank of TIMER_COUNT down-counting timers whose period, count and flag bits
// live in a single entry memory with a registered read. Every command beat
// yields exactly one result beat. Entry zero is reserved; allocate hands out
// ids from one upward until the bank is full. A tick walks the memory through
// its single read port, one entry per cycle, writing each entry back in the
// cycle after its read, and then waits to load its result. Allocate, start
// and rejected commands go straight to the result wait state; stop and query
// first pass through a read-modify-write state. The input stalls until the
// result is loaded, and a new command is accepted in the cycle after that,
// even while the result is still stalled. A finished command whose result
// cannot enter the output register holds off the next command until the
// receiver takes the pending beat. The memory needs no clearing pass:
// per-entry valid bits make unwritten entries read as zero right after reset.
module multi_timer_bank_unit
    import mtb_pkg::*;
#(
    parameter int TIMER_COUNT = TIMER_COUNT_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [3:0]  timer_id,
    input  logic [31:0] period_ticks,
    input  logic        periodic_mode,
    input  logic        notify_enable,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [3:0]  allocated_id,
    output logic        expired_flag,
    output logic [15:0] event_mask
);

    localparam int AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int DW = 2 * COUNT_WIDTH + 4;

    // memory port between sequencer and store
    mem_ctl_t      mem_ctl;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [DW-1:0] rd_data;

    // sequencer: decodes each beat and runs the read-modify-write passes
    mtb_ctrl #(
        .TIMER_COUNT (TIMER_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .timer_id      (timer_id),
        .period_ticks  (period_ticks),
        .periodic_mode (periodic_mode),
        .notify_enable (notify_enable),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .allocated_id  (allocated_id),
        .expired_flag  (expired_flag),
        .event_mask    (event_mask),
        .mem_ctl       (mem_ctl),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_data       (rd_data)
    );

    // entry memory: one write and one registered read per cycle
    mtb_store #(
        .TIMER_COUNT (TIMER_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_ctl (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

endmodule
